// ===== rtl/ptr_pkg.sv =====
// Shared types, constants and saturation helpers for the packet timestamp retimer.
package ptr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int TS_W       = 63;
  localparam int CFG_DATA_W = 63;
  localparam int CFG_IDX_W  = 3;
  localparam int PAUSE_W    = 40;
  localparam int BYTES_W    = 16;
  localparam int AMT_W      = 56;
  localparam int PROD_W     = 96;

  localparam logic [FRAC_BITS-1:0] FRAC_MASK = {FRAC_BITS{1'b1}};
  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  localparam logic [1:0] ADJ_SCALE = 2'd0;
  localparam logic [1:0] ADJ_RATE  = 2'd1;
  localparam logic [1:0] ADJ_BAND  = 2'd2;

  localparam logic [1:0] START_INPUT   = 2'd0;
  localparam logic [1:0] START_ABS     = 2'd1;
  localparam logic [1:0] START_CURRENT = 2'd2;

  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_PAUSE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ADJUST_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_AT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_SCALE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_GAP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_TIME    = 3'd6;

  typedef struct packed {
    logic [1:0]  adjust_mode;
    logic [1:0]  start_mode;
    logic [62:0] start_offset_ns;
    logic [62:0] start_at_ns;
    logic [31:0] gap_scale_q16;
    logic [47:0] packet_gap_ns_q16;
    logic [39:0] byte_time_ns_q16;
  } cfg_t;

  typedef struct packed {
    logic              pause;
    logic              first;
    logic              neg;
    logic [TS_W-1:0]   mag;
    logic [63:0]       t1;
    logic [TS_W-1:0]   x;
    logic [AMT_W-1:0]  amount;
    logic [PAUSE_W-1:0] pause_ns;
  } front_item_t;

  typedef struct packed {
    logic                 pause;
    logic                 first;
    logic [AMT_W-1:0]     amount;
    logic [PAUSE_W-1:0]   pause_ns;
    logic [63:0]          start;
    logic [63:0]          off;
    logic [FRAC_BITS-1:0] off_frac;
  } scale_item_t;

  function automatic logic sat_top(input logic [64:0] s);
    return s[64:63] == 2'b01;
  endfunction

  function automatic logic sat_bottom(input logic [64:0] s);
    return s[64:63] == 2'b10;
  endfunction

  // clamp a 65-bit signed sum to the signed 64-bit range
  function automatic logic [63:0] sat_clamp(input logic [64:0] s);
    logic [63:0] r;
    if (sat_top(s)) begin
      r = S64_MAX;
    end else if (sat_bottom(s)) begin
      r = S64_MIN;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ptr_front.sv =====
// Input stage: first-packet tracking, gap magnitude, start terms and advance amount.
module ptr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  ptr_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [ptr_pkg::TS_W-1:0]      packet_ts_ns,
  input  logic [ptr_pkg::BYTES_W-1:0]   packet_bytes,
  input  logic [ptr_pkg::TS_W-1:0]      now_ns,
  input  logic [ptr_pkg::PAUSE_W-1:0]   pause_ns,
  output logic                          item_valid,
  input  logic                          item_ready,
  output ptr_pkg::front_item_t          item
);
  import ptr_pkg::*;

  logic               started;
  logic [TS_W-1:0]    ref_ns;
  logic [TS_W-1:0]    pause_acc;
  logic [BYTES_W-1:0] last_bytes;

  logic               take;
  logic               is_pause;
  logic               is_first;
  logic [TS_W-1:0]    ref_sel;
  logic [63:0]        acc_sum;
  logic [64:0]        t1_sum;
  logic [AMT_W-1:0]   band_amount;
  front_item_t        item_next;

  assign in_ready = !item_valid || item_ready;
  assign take     = in_valid && in_ready;
  assign is_pause = (action == ACT_PAUSE);
  assign is_first = !is_pause && !started;
  assign ref_sel  = is_first ? packet_ts_ns : ref_ns;

  // pauses seen before the first packet push the start time
  assign acc_sum = {1'b0, pause_acc} + {24'b0, pause_ns};
  assign t1_sum  = {2'b0, pause_acc} + {{2{cfg.start_offset_ns[62]}}, cfg.start_offset_ns};
  assign band_amount = AMT_W'(cfg.byte_time_ns_q16) * AMT_W'(last_bytes);

  always_comb begin
    item_next.pause    = is_pause;
    item_next.first    = is_first;
    item_next.neg      = packet_ts_ns < ref_sel;
    item_next.mag      = item_next.neg ? (ref_sel - packet_ts_ns) : (packet_ts_ns - ref_sel);
    item_next.t1       = sat_clamp(t1_sum);
    item_next.x        = (cfg.start_mode == START_CURRENT) ? now_ns : packet_ts_ns;
    item_next.amount   = (cfg.adjust_mode == ADJ_RATE) ? AMT_W'(cfg.packet_gap_ns_q16)
                                                       : band_amount;
    item_next.pause_ns = pause_ns;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      started    <= 1'b0;
      ref_ns     <= '0;
      pause_acc  <= '0;
      last_bytes <= '0;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (take && is_first) begin
        started <= 1'b1;
        ref_ns  <= packet_ts_ns;
      end
      if (take && is_pause && !started) begin
        pause_acc <= acc_sum[63] ? {TS_W{1'b1}} : acc_sum[TS_W-1:0];
      end
      if (take && !is_pause) begin
        last_bytes <= packet_bytes;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

  a_started_holds: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("first-packet flag dropped without reset");

  a_first_zero_gap: assert property (@(posedge clk) disable iff (rst)
    item_valid && item.first |-> !item.pause && item.mag == '0)
    else $error("first packet item carries a pause or a nonzero gap");

endmodule

// ===== rtl/ptr_scale.sv =====
// Scaled-gap pipeline: start time, partial products, saturation and signed offset.
module ptr_scale (
  input  logic                  clk,
  input  logic                  rst,
  input  ptr_pkg::cfg_t         cfg,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  ptr_pkg::front_item_t  item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ptr_pkg::scale_item_t  out_item
);
  import ptr_pkg::*;

  typedef struct packed {
    logic               pause;
    logic               first;
    logic               neg;
    logic [AMT_W-1:0]   amount;
    logic [PAUSE_W-1:0] pause_ns;
    logic [63:0]        start;
    logic [63:0]        p_lo;
    logic [62:0]        p_hi;
  } mul_t;

  typedef struct packed {
    logic                 pause;
    logic                 first;
    logic                 neg;
    logic [AMT_W-1:0]     amount;
    logic [PAUSE_W-1:0]   pause_ns;
    logic [63:0]          start;
    logic [TS_W-1:0]      ip;
    logic [FRAC_BITS-1:0] fp;
  } sum_t;

  logic        a_valid, b_valid;
  logic        a_ready, b_ready, c_ready;
  mul_t        a, a_next;
  sum_t        b, b_next;
  scale_item_t c_next;

  logic [64:0]          st_sum;
  logic [PROD_W-1:0]    prod;
  logic                 prod_sat;
  logic [63:0]          ip_ext;
  logic [FRAC_BITS-1:0] fp_neg;

  assign c_ready    = !out_valid || out_ready;
  assign b_ready    = !b_valid || c_ready;
  assign a_ready    = !a_valid || b_ready;
  assign item_ready = a_ready;

  // first stage: start time and two partial products of the low 32 and high 31 magnitude bits
  assign st_sum = {item.t1[63], item.t1} + {2'b0, item.x};

  always_comb begin
    a_next.pause    = item.pause;
    a_next.first    = item.first;
    a_next.neg      = item.neg;
    a_next.amount   = item.amount;
    a_next.pause_ns = item.pause_ns;
    a_next.start    = (cfg.start_mode == START_ABS) ? {1'b0, cfg.start_at_ns}
                                                    : sat_clamp(st_sum);
    a_next.p_lo     = 64'(item.mag[31:0]) * 64'(cfg.gap_scale_q16);
    a_next.p_hi     = 63'(item.mag[TS_W-1:32]) * 63'(cfg.gap_scale_q16);
  end

  // second stage: combine products, floor to ns, clamp magnitude
  assign prod     = {32'b0, a.p_lo} + {1'b0, a.p_hi, 32'b0};
  assign prod_sat = |prod[PROD_W-1:FRAC_BITS+TS_W];

  always_comb begin
    b_next.pause    = a.pause;
    b_next.first    = a.first;
    b_next.neg      = a.neg;
    b_next.amount   = a.amount;
    b_next.pause_ns = a.pause_ns;
    b_next.start    = a.start;
    b_next.ip       = prod_sat ? {TS_W{1'b1}} : prod[FRAC_BITS+TS_W-1:FRAC_BITS];
    b_next.fp       = prod_sat ? FRAC_MASK : prod[FRAC_BITS-1:0];
  end

  // third stage: apply sign, borrow from the integer part for a negative fraction
  assign ip_ext = {1'b0, b.ip};
  assign fp_neg = ~b.fp + FRAC_BITS'(1);

  always_comb begin
    c_next.pause    = b.pause;
    c_next.first    = b.first;
    c_next.amount   = b.amount;
    c_next.pause_ns = b.pause_ns;
    c_next.start    = b.start;
    if (!b.neg) begin
      c_next.off      = ip_ext;
      c_next.off_frac = b.fp;
    end else if (b.fp == '0) begin
      c_next.off      = 64'd0 - ip_ext;
      c_next.off_frac = '0;
    end else begin
      c_next.off      = ~ip_ext;
      c_next.off_frac = fp_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= item_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && item_valid) begin
      a <= a_next;
    end
    if (b_ready && a_valid) begin
      b <= b_next;
    end
    if (c_ready && b_valid) begin
      out_item <= c_next;
    end
  end

  a_first_no_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.first |-> out_item.off == 64'd0 && out_item.off_frac == '0)
    else $error("first packet reached commit with a nonzero scaled offset");

endmodule

// ===== rtl/ptr_commit.sv =====
// Commit stage: last output time state, pause and advance arithmetic, output register.
module ptr_commit (
  input  logic                         clk,
  input  logic                         rst,
  input  ptr_pkg::cfg_t                cfg,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  ptr_pkg::scale_item_t         item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ptr_pkg::TS_W-1:0]     ts_out_ns
);
  import ptr_pkg::*;

  logic [63:0]          last_out, last_out_next;
  logic [FRAC_BITS-1:0] last_frac, last_frac_next;
  logic [63:0]          base_out, base_out_next;

  logic                          take;
  logic [63:0]                   cur_l, cur_base;
  logic [FRAC_BITS-1:0]          cur_frac;
  logic [64:0]                   pause_sum, adv_sum, scl_sum;
  logic [FRAC_BITS:0]            frac_sum;
  logic [AMT_W-FRAC_BITS:0]      whole;

  assign item_ready = !out_valid || !out_stall;
  assign take       = item_valid && item_ready;

  // first packet: load the start time before retiming
  assign cur_l    = item.first ? item.start : last_out;
  assign cur_frac = item.first ? '0 : last_frac;
  assign cur_base = item.first ? item.start : base_out;

  assign pause_sum = {last_out[63], last_out} + 65'(item.pause_ns);
  assign frac_sum  = {1'b0, cur_frac} + {1'b0, item.amount[FRAC_BITS-1:0]};
  assign whole     = {1'b0, item.amount[AMT_W-1:FRAC_BITS]} + (AMT_W-FRAC_BITS+1)'(frac_sum[FRAC_BITS]);
  assign adv_sum   = {cur_l[63], cur_l} + 65'(whole);
  assign scl_sum   = {cur_base[63], cur_base} + {item.off[63], item.off};

  always_comb begin
    last_out_next  = last_out;
    last_frac_next = last_frac;
    base_out_next  = base_out;
    if (item.pause) begin
      last_out_next  = sat_clamp(pause_sum);
      last_frac_next = sat_top(pause_sum) ? FRAC_MASK : last_frac;
    end else begin
      base_out_next = cur_base;
      case (cfg.adjust_mode)
        ADJ_RATE, ADJ_BAND: begin
          last_out_next  = sat_clamp(adv_sum);
          last_frac_next = sat_top(adv_sum) ? FRAC_MASK : frac_sum[FRAC_BITS-1:0];
        end
        default: begin
          last_out_next = sat_clamp(scl_sum);
          if (sat_top(scl_sum)) begin
            last_frac_next = FRAC_MASK;
          end else if (sat_bottom(scl_sum)) begin
            last_frac_next = '0;
          end else begin
            last_frac_next = item.off_frac;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_out  <= '0;
      last_frac <= '0;
      base_out  <= '0;
    end else begin
      if (item_ready) begin
        out_valid <= item_valid && !item.pause;
      end
      if (take) begin
        last_out  <= last_out_next;
        last_frac <= last_frac_next;
        base_out  <= base_out_next;
      end
    end
  end

  // floor is already taken; clamp negative times to zero
  always_ff @(posedge clk) begin
    if (take && !item.pause) begin
      ts_out_ns <= last_out_next[63] ? '0 : last_out_next[TS_W-1:0];
    end
  end

  a_result_from_packet: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(take && !item.pause))
    else $error("result raised without a packet item committed");

endmodule

// ===== rtl/packet_timestamp_retimer_unit.sv =====
// Top level of the packet timestamp retimer: configuration registers and pipeline.
// A packet item is registered in the front stage, in each scale stage and in the commit output register.
// Throughput: one item per cycle while out_stall is low; the last-output update closes in the commit stage.
// Pause items take one slot in the pipeline and give no result.
// Reset (rst, synchronous) clears all valids, retiming state and configuration
// registers to their defaults (gap scale 1.0).
module packet_timestamp_retimer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ptr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [ptr_pkg::TS_W-1:0]          packet_ts_ns,
  input  logic [ptr_pkg::BYTES_W-1:0]       packet_bytes,
  input  logic [ptr_pkg::TS_W-1:0]          now_ns,
  input  logic [ptr_pkg::PAUSE_W-1:0]       pause_ns,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ptr_pkg::TS_W-1:0]          ts_out_ns
);
  import ptr_pkg::*;

  cfg_t        cfg;
  logic        in_ready;
  logic        f_valid, f_ready;
  front_item_t f_item;
  logic        s_valid, s_ready;
  scale_item_t s_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adjust_mode       <= ADJ_SCALE;
      cfg.start_mode        <= START_INPUT;
      cfg.start_offset_ns   <= '0;
      cfg.start_at_ns       <= '0;
      cfg.gap_scale_q16     <= 32'd65536;
      cfg.packet_gap_ns_q16 <= '0;
      cfg.byte_time_ns_q16  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ADJUST_MODE:  cfg.adjust_mode       <= cfg_data[1:0];
        REG_START_MODE:   cfg.start_mode        <= cfg_data[1:0];
        REG_START_OFFSET: cfg.start_offset_ns   <= cfg_data[62:0];
        REG_START_AT:     cfg.start_at_ns       <= cfg_data[62:0];
        REG_GAP_SCALE:    cfg.gap_scale_q16     <= cfg_data[31:0];
        REG_PACKET_GAP:   cfg.packet_gap_ns_q16 <= cfg_data[47:0];
        REG_BYTE_TIME:    cfg.byte_time_ns_q16  <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !in_ready;

  ptr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .packet_ts_ns (packet_ts_ns),
    .packet_bytes (packet_bytes),
    .now_ns       (now_ns),
    .pause_ns     (pause_ns),
    .item_valid   (f_valid),
    .item_ready   (f_ready),
    .item         (f_item)
  );

  ptr_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item),
    .out_valid  (s_valid),
    .out_ready  (s_ready),
    .out_item   (s_item)
  );

  ptr_commit u_commit (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (s_valid),
    .item_ready (s_ready),
    .item       (s_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ts_out_ns  (ts_out_ns)
  );

endmodule
